>>> rtl/core/bcdc_pkg.sv
// Shared constants and helpers for the BCD coprocessor.
// No dependencies.
package bcdc_pkg;

  localparam int BANK_BYTES = 12;
  localparam int NUM_BANKS  = 4;
  localparam int MEM_DEPTH  = BANK_BYTES * NUM_BANKS;
  localparam int AW         = $clog2(MEM_DEPTH);

  localparam logic [7:0] OFF_CTRL   = 8'h00;
  localparam logic [7:0] OFF_WCOUNT = 8'h02;
  localparam logic [7:0] OFF_STATUS = 8'h10;
  localparam logic [7:0] OFF_LOZ    = 8'h14;
  localparam logic [7:0] OFF_HIZ    = 8'h15;
  localparam logic [7:0] CTRL_IDLE  = 8'hFF;

  localparam logic [3:0] OP_COUNT = 4'd0;
  localparam logic [3:0] OP_ADD   = 4'd1;
  localparam logic [3:0] OP_SUB   = 4'd2;
  localparam logic [3:0] OP_SHU   = 4'd8;
  localparam logic [3:0] OP_SHD   = 4'd9;
  localparam logic [3:0] OP_CLR   = 4'd10;
  localparam logic [3:0] OP_CPY   = 4'd11;
  localparam logic [3:0] OP_SHUF  = 4'd12;
  localparam logic [3:0] OP_SHDF  = 4'd13;

  // two BCD digits with carry chain; returns {carry, byte}
  function automatic logic [8:0] bcd_byte(input logic [7:0] x, input logic [7:0] y,
                                          input logic cin, input logic sub);
    logic       c;
    logic [3:0] yd;
    logic [4:0] s;
    logic [7:0] r;
    c = cin;
    r = 8'h00;
    for (int d = 0; d < 2; d++) begin
      yd = sub ? 4'(4'd9 - y[4*d +: 4]) : y[4*d +: 4];
      s  = 5'(x[4*d +: 4]) + 5'(yd) + 5'(c);
      c  = 1'b0;
      if (s >= 5'd10) begin
        s = s - 5'd10;
        c = 1'b1;
      end
      r[4*d +: 4] = s[3:0];
    end
    return {c, r};
  endfunction

  function automatic logic [AW-1:0] mem_addr(input logic [1:0] b, input logic [3:0] k);
    return AW'(AW'(b) * AW'(BANK_BYTES) + AW'(k));
  endfunction

endpackage

>>> rtl/core/bcd_arithmetic_coprocessor.sv
// BCD coprocessor: bus decode, command sequencer and the 48-byte bank memory.
// Register and bank-write replies come in the cycle after acceptance; bank reads
// pass the memory register, then read_data. A control write returns at once, then
// the sequencer holds the input through add/sub, shift/clear/copy and zero count.
// One register word per cycle while idle and unstalled; bank reads never overlap.
// Synchronous reset clears the registers; bank bytes read as zero until written.
module bcd_arithmetic_coprocessor
  import bcdc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       is_write,
  input  logic [7:0] page_offset,
  input  logic [7:0] write_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data
);

  typedef enum logic [1:0] {S_IDLE, S_BUSRD, S_RD, S_EX} state_t;
  typedef enum logic [1:0] {P_ARITH, P_ACT, P_CNT} phase_t;

  logic [7:0]    mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] vld;
  logic [7:0]    mem_a, mem_b;
  logic          vld_a, vld_b;
  logic [7:0]    rdata_a, rdata_b;
  logic [AW-1:0] raddr_a, raddr_b, waddr;
  logic [7:0]    wdata;
  logic          we;

  state_t     state;
  phase_t     phase;
  logic [3:0] op, j, lim;
  logic [1:0] srcb, dstb;
  logic [2:0] word_count;
  logic [7:0] status_flags, low_zero_digits, high_zero_digits;
  logic       carry, zero, cchain, lowz, hdone, ldone;

  logic       acc, bus_bank;
  logic [AW-1:0] bus_addr;
  logic       sub, store, up, fill, inner, last_word, act_op;
  logic [3:0] k, s;
  logic [1:0] nbank, bbank;
  logic [3:0] bk;
  logic [8:0] bres;
  logic       cin, carry_next, zero_next;
  logic [7:0] act_val;
  logic [7:0] hi_next, lo_next;
  logic       hd_next, ld_next;
  logic [3:0] ka;
  logic [2:0] wpad;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign acc      = in_valid && in_ready;
  assign bus_bank = page_offset[7] && (page_offset[4:0] < 5'(BANK_BYTES));
  assign bus_addr = mem_addr(page_offset[6:5], page_offset[3:0]);

  assign sub    = (op == OP_SUB);
  assign store  = (op == OP_ADD) || (op == OP_SUB);
  assign up     = (op == OP_SHU) || (op == OP_SHUF);
  assign fill   = (op == OP_SHUF) || (op == OP_SHDF);
  assign act_op = (op >= OP_SHU) && (op <= OP_SHDF);
  assign wpad   = word_count + 3'(word_count[0]);
  assign ka     = 4'(BANK_BYTES - 1) - j;

  // operand addressing, shared by the read and execute cycles of a step
  always_comb begin
    k       = (phase == P_ACT && up) ? ka : j;
    s       = (srcb == 2'd2) ? 4'd2 : ((srcb == 2'd3) ? 4'd4 : 4'd1);
    nbank   = up ? dstb - 2'd1 : dstb + 2'd1;
    inner   = 1'b0;
    bbank   = dstb;
    bk      = k;
    raddr_a = mem_addr(dstb, k);
    raddr_b = mem_addr(srcb, k);
    case (phase)
      P_ARITH: raddr_b = mem_addr(srcb, j);
      P_ACT: begin
        if (op == OP_CPY) begin
          bbank = srcb;
          bk    = k;
        end else if (up) begin
          inner = (k >= s);
          bbank = inner ? dstb : nbank;
          bk    = inner ? k - s : 4'(BANK_BYTES) - s + k;
        end else begin
          inner = (5'(k) + 5'(s) < 5'(BANK_BYTES));
          bbank = inner ? dstb : nbank;
          bk    = inner ? k + s : k + s - 4'(BANK_BYTES);
        end
        raddr_b = mem_addr(bbank, bk);
      end
      P_CNT: begin
        raddr_a = mem_addr(dstb, ka);
        raddr_b = mem_addr(dstb, j);
      end
      default: ;
    endcase
    if (state == S_IDLE) raddr_a = bus_addr;
  end

  // execute-cycle datapath
  always_comb begin
    last_word  = word_count[0] && (j[3:1] == word_count);
    cin        = j[0] ? cchain : (carry ^ sub);
    bres       = bcd_byte(rdata_a, rdata_b, cin, sub);
    carry_next = carry;
    zero_next  = zero;
    if (j[0] && !last_word) begin
      carry_next = bres[8] ^ sub;
      zero_next  = zero && lowz && (bres[7:0] == 8'h00);
    end

    if (op == OP_CLR) act_val = (j == 4'd0) ? ((srcb == 2'd3) ? 8'd5 : 8'(srcb)) : 8'h00;
    else if (op == OP_CPY) act_val = rdata_b;
    else if (srcb == 2'd0) begin
      if (up) act_val = {rdata_a[3:0], (inner || fill) ? rdata_b[7:4] : 4'h0};
      else    act_val = {(inner || fill) ? rdata_b[3:0] : 4'h0, rdata_a[7:4]};
    end else act_val = (inner || fill) ? rdata_b : 8'h00;

    hi_next = high_zero_digits;
    lo_next = low_zero_digits;
    hd_next = hdone;
    ld_next = ldone;
    if (!hdone) begin
      if (ka >= lim) hi_next = hi_next + 8'd2;
      else if (rdata_a[7:4] != 4'h0) hd_next = 1'b1;
      else begin
        hi_next = hi_next + 8'd1;
        if (rdata_a[3:0] != 4'h0) hd_next = 1'b1;
        else hi_next = hi_next + 8'd1;
      end
    end
    if (!ldone) begin
      if (j < lim) begin
        if (rdata_b[3:0] != 4'h0) ld_next = 1'b1;
        else begin
          lo_next = lo_next + 8'd1;
          if (rdata_b[7:4] != 4'h0) ld_next = 1'b1;
          else lo_next = lo_next + 8'd1;
        end
      end else hi_next = hi_next + 8'd2;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = bus_addr;
    wdata = write_data;
    if (state == S_IDLE) begin
      we = acc && is_write && bus_bank;
    end else if (state == S_EX) begin
      waddr = mem_addr(dstb, k);
      if (phase == P_ARITH) begin
        we    = store;
        wdata = last_word ? 8'h00 : bres[7:0];
      end else if (phase == P_ACT) begin
        we    = 1'b1;
        wdata = act_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    mem_a <= mem[raddr_a];
    mem_b <= mem[raddr_b];
  end

  // per-byte written marks: unwritten bank bytes read as zero
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (we) vld[waddr] <= 1'b1;
    vld_a <= vld[raddr_a];
    vld_b <= vld[raddr_b];
  end

  assign rdata_a = vld_a ? mem_a : 8'h00;
  assign rdata_b = vld_b ? mem_b : 8'h00;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      phase            <= P_CNT;
      out_valid        <= 1'b0;
      read_data        <= 8'h00;
      word_count       <= 3'd0;
      status_flags     <= 8'h00;
      low_zero_digits  <= 8'h00;
      high_zero_digits <= 8'h00;
      op <= 4'd0; srcb <= 2'd0; dstb <= 2'd0; j <= 4'd0; lim <= 4'd0;
      carry <= 1'b0; zero <= 1'b1; cchain <= 1'b0; lowz <= 1'b0;
      hdone <= 1'b0; ldone <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (acc) begin
            if (is_write) begin
              out_valid <= 1'b1;
              read_data <= 8'h00;
              case (page_offset)
                OFF_CTRL: begin
                  if (write_data != CTRL_IDLE) begin
                    op    <= write_data[7:4];
                    srcb  <= write_data[3:2];
                    dstb  <= write_data[1:0];
                    j     <= 4'd0;
                    state <= S_RD;
                    carry <= 1'b0;
                    zero  <= 1'b1;
                    hdone <= 1'b0;
                    ldone <= 1'b0;
                    if (write_data[7:4] == OP_COUNT) begin
                      phase            <= P_CNT;
                      lim              <= {word_count, 1'b0};
                      low_zero_digits  <= 8'h00;
                      high_zero_digits <= 8'h00;
                    end else if (word_count != 3'd0) begin
                      phase <= P_ARITH;
                      lim   <= {wpad, 1'b0};
                    end else if (write_data[7:4] >= OP_SHU && write_data[7:4] <= OP_SHDF) begin
                      phase <= P_ACT;
                    end else begin
                      phase            <= P_CNT;
                      lim              <= 4'(BANK_BYTES);
                      low_zero_digits  <= 8'h00;
                      high_zero_digits <= 8'h00;
                    end
                  end
                end
                OFF_WCOUNT: word_count <= (write_data == 8'd0) ? 3'd1 :
                                          ((write_data > 8'd6) ? 3'd6 : write_data[2:0]);
                OFF_STATUS: status_flags     <= write_data;
                OFF_LOZ:    low_zero_digits  <= write_data;
                OFF_HIZ:    high_zero_digits <= write_data;
                default: ;
              endcase
            end else if (bus_bank) begin
              state <= S_BUSRD;
            end else begin
              out_valid <= 1'b1;
              case (page_offset)
                OFF_CTRL:   read_data <= CTRL_IDLE;
                OFF_WCOUNT: read_data <= {5'd0, word_count};
                OFF_STATUS: read_data <= status_flags;
                OFF_LOZ:    read_data <= low_zero_digits;
                OFF_HIZ:    read_data <= high_zero_digits;
                default:    read_data <= 8'h00;
              endcase
            end
          end
        end
        S_BUSRD: begin
          out_valid <= 1'b1;
          read_data <= rdata_a;
          state     <= S_IDLE;
        end
        S_RD: state <= S_EX;
        S_EX: begin
          state <= S_RD;
          j     <= j + 4'd1;
          case (phase)
            P_ARITH: begin
              if (!j[0]) begin
                cchain <= bres[8];
                lowz   <= (bres[7:0] == 8'h00);
              end
              carry <= carry_next;
              zero  <= zero_next;
              if (j == lim - 4'd1) begin
                status_flags <= {carry_next, zero_next, 6'd0};
                j            <= 4'd0;
                if (act_op) phase <= P_ACT;
                else begin
                  phase            <= P_CNT;
                  lim              <= 4'(BANK_BYTES);
                  low_zero_digits  <= 8'h00;
                  high_zero_digits <= 8'h00;
                end
              end
            end
            P_ACT: begin
              if (j == 4'(BANK_BYTES - 1)) begin
                j                <= 4'd0;
                phase            <= P_CNT;
                lim              <= 4'(BANK_BYTES);
                low_zero_digits  <= 8'h00;
                high_zero_digits <= 8'h00;
              end
            end
            P_CNT: begin
              high_zero_digits <= hi_next;
              low_zero_digits  <= lo_next;
              hdone            <= hd_next;
              ldone            <= ld_next;
              if (j == 4'(BANK_BYTES - 1)) state <= S_IDLE;
            end
            default: ;
          endcase
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
